### rtl/vct_pkg.sv
package vct_pkg;

    localparam int MAX_THREADS = 8;
    localparam int STAMP_BITS  = 16;

    localparam int ROW_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CNT_W  = $clog2(MAX_THREADS + 1);
    localparam int ADDR_W = $clog2(MAX_THREADS * MAX_THREADS);

    typedef logic signed [STAMP_BITS-1:0] t_stamp;
    typedef logic [ROW_W-1:0]             t_row;
    typedef logic [CNT_W-1:0]             t_count;
    typedef logic [ADDR_W-1:0]            t_addr;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_FORK  = 3'd1,
        OP_MERGE = 3'd2,
        OP_CMP   = 3'd3,
        OP_WRITE = 3'd4,
        OP_READ  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_THREAD = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FLUSH,
        S_READ,
        S_RESP
    } t_state;

    localparam t_stamp STAMP_UNSET = '1;

    // Flat address of entry idx within row
    function automatic t_addr addr_of(input t_row row, input t_row idx);
        return ADDR_W'(int'(row) * MAX_THREADS + int'(idx));
    endfunction

endpackage

### rtl/vector_clock_table.sv
// Vector clock table: fork, merge and compare walk one row entry per cycle.
// A request is latched, then checked; fork, merge and compare go on through the scan and a
// flush step, read through a read step, and start, write and every error go straight to the result.
// Busy stays high through the result cycle, so a new request is taken only once the last one
// has finished. o_done strobes one cycle; no stall.
// Synchronous active-low reset clears the thread count and all entry valid bits.
module vector_clock_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [2:0]  i_thread_a,
    input  logic [2:0]  i_thread_b,
    input  logic [2:0]  i_position,
    input  logic signed [15:0] i_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [2:0]  o_new_thread,
    output logic        o_a_before_b,
    output logic        o_b_before_a,
    output logic        o_concurrent,
    output logic signed [15:0] o_read_value
);

    localparam int N    = vct_pkg::MAX_THREADS;
    localparam int NENT = N * N;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    vct_pkg::t_state r_state, n_state;
    vct_pkg::t_count r_count, n_count;
    vct_pkg::t_row   r_idx,   n_idx;     // entry being read
    vct_pkg::t_row   r_pidx,  n_pidx;    // entry whose read data is back
    logic            r_pv,    n_pv;      // read data in flight is meaningful
    logic [NENT-1:0] r_valid;            // entry written since reset

    // Latched request
    vct_pkg::t_op    r_op,    n_op;
    logic [2:0]      r_ta,    n_ta;
    logic [2:0]      r_tb,    n_tb;
    logic [2:0]      r_pos,   n_pos;
    logic signed [15:0] r_value, n_value;

    // Result registers
    vct_pkg::t_status r_status, n_status;
    logic [2:0]      r_new,   n_new;
    logic            r_ab,    n_ab;
    logic            r_ba,    n_ba;
    logic            r_cmp,   n_cmp;
    logic signed [15:0] r_read, n_read;

    // ------------------------------------------------------------------
    // Timestamp memory: one write port, two registered read ports.
    // Unwritten entries read as unset through the valid bits.
    // ------------------------------------------------------------------
    vct_pkg::t_stamp mem [NENT];
    vct_pkg::t_stamp r_rd_a, r_rd_b;
    logic            r_rv_a, r_rv_b;

    logic            mem_we;
    vct_pkg::t_addr  mem_waddr;
    vct_pkg::t_stamp mem_wdata;
    vct_pkg::t_addr  raddr_a, raddr_b;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= mem[raddr_a];
        r_rd_b <= mem[raddr_b];
        r_rv_a <= r_valid[raddr_a];
        r_rv_b <= r_valid[raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[mem_waddr] <= 1'b1;
        end
    end

    vct_pkg::t_stamp va, vb;
    assign va = r_rv_a ? r_rd_a : vct_pkg::STAMP_UNSET;
    assign vb = r_rv_b ? r_rd_b : vct_pkg::STAMP_UNSET;

    // ------------------------------------------------------------------
    // Request checks
    // ------------------------------------------------------------------
    logic ta_ok, tb_ok, pos_ok, room;
    vct_pkg::t_row row_a, row_b, row_c, pos_row;

    assign ta_ok   = 32'(r_ta)  < 32'(r_count);
    assign tb_ok   = 32'(r_tb)  < 32'(r_count);
    assign pos_ok  = 32'(r_pos) < 32'(r_count);
    assign room    = 32'(r_count) < N;
    assign row_a   = vct_pkg::t_row'(r_ta);
    assign row_b   = vct_pkg::t_row'(r_tb);
    assign row_c   = vct_pkg::t_row'(r_count);
    assign pos_row = vct_pkg::t_row'(r_pos);

    logic last_idx;
    assign last_idx = (r_idx == vct_pkg::t_row'(N - 1));

    // ------------------------------------------------------------------
    // Sequencer and the shared compare unit
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pv     = r_pv;
        n_op     = r_op;
        n_ta     = r_ta;
        n_tb     = r_tb;
        n_pos    = r_pos;
        n_value  = r_value;
        n_status = r_status;
        n_new    = r_new;
        n_ab     = r_ab;
        n_ba     = r_ba;
        n_cmp    = r_cmp;
        n_read   = r_read;

        mem_we    = 1'b0;
        mem_waddr = vct_pkg::addr_of(row_a, r_pidx);
        mem_wdata = va;
        raddr_a   = vct_pkg::addr_of(row_a, r_idx);
        raddr_b   = vct_pkg::addr_of(row_b, r_idx);

        unique case (r_state)
            vct_pkg::S_IDLE: begin
                if (start) begin
                    n_op     = vct_pkg::t_op'(i_op);
                    n_ta     = i_thread_a;
                    n_tb     = i_thread_b;
                    n_pos    = i_position;
                    n_value  = i_value;
                    n_status = vct_pkg::STS_OK;
                    n_new    = '0;
                    n_ab     = 1'b0;
                    n_ba     = 1'b0;
                    n_cmp    = 1'b0;
                    n_read   = '0;
                    n_state  = vct_pkg::S_CHECK;
                end
            end

            vct_pkg::S_CHECK: begin
                n_idx   = '0;
                n_pv    = 1'b0;
                n_state = vct_pkg::S_RESP;
                raddr_a = vct_pkg::addr_of(row_a, pos_row);
                unique case (r_op)
                    vct_pkg::OP_START: begin
                        if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = vct_pkg::addr_of('0, '0);
                            mem_wdata = '0;
                            n_count   = vct_pkg::t_count'(1);
                        end
                    end
                    vct_pkg::OP_FORK: begin
                        if (!ta_ok) begin
                            n_status = vct_pkg::STS_NO_THREAD;
                        end else if (!room) begin
                            n_status = vct_pkg::STS_FULL;
                        end else begin
                            n_state = vct_pkg::S_SCAN;
                        end
                    end
                    vct_pkg::OP_MERGE: begin
                        if (!ta_ok || !tb_ok) begin
                            n_status = vct_pkg::STS_NO_THREAD;
                        end else begin
                            n_state = vct_pkg::S_SCAN;
                        end
                    end
                    vct_pkg::OP_CMP: begin
                        if (!ta_ok || !tb_ok) begin
                            n_status = vct_pkg::STS_NO_THREAD;
                        end else begin
                            n_ab    = 1'b1;
                            n_ba    = 1'b1;
                            n_cmp   = 1'b1;
                            n_state = vct_pkg::S_SCAN;
                        end
                    end
                    vct_pkg::OP_WRITE: begin
                        if (!ta_ok || !pos_ok) begin
                            n_status = vct_pkg::STS_NO_THREAD;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = vct_pkg::addr_of(row_a, pos_row);
                            mem_wdata = vct_pkg::STAMP_BITS'(r_value);
                        end
                    end
                    vct_pkg::OP_READ: begin
                        if (!ta_ok || !pos_ok) begin
                            n_status = vct_pkg::STS_NO_THREAD;
                        end else begin
                            n_state = vct_pkg::S_READ;
                        end
                    end
                    default: begin
                        // unused op codes: plain ok result
                    end
                endcase
            end

            vct_pkg::S_SCAN, vct_pkg::S_FLUSH: begin
                // Retire the entry whose data came back this cycle
                if (r_pv || r_state == vct_pkg::S_FLUSH) begin
                    unique case (r_op)
                        vct_pkg::OP_FORK: begin
                            mem_we    = 1'b1;
                            mem_waddr = vct_pkg::addr_of(row_c, r_pidx);
                            mem_wdata = (r_pidx == row_c) ? '0 : va;
                        end
                        vct_pkg::OP_MERGE: begin
                            mem_we    = 1'b1;
                            mem_waddr = vct_pkg::addr_of(row_a, r_pidx);
                            mem_wdata = (vb > va) ? vb : va;
                        end
                        vct_pkg::OP_CMP: begin
                            if (va > vb) begin
                                n_ab = 1'b0;
                            end
                            if (vb > va) begin
                                n_ba = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                if (r_state == vct_pkg::S_SCAN) begin
                    n_pidx = r_idx;
                    n_pv   = 1'b1;
                    if (last_idx) begin
                        n_state = vct_pkg::S_FLUSH;
                    end else begin
                        n_idx = r_idx + vct_pkg::t_row'(1);
                    end
                end else begin
                    if (r_op == vct_pkg::OP_FORK) begin
                        n_count = r_count + vct_pkg::t_count'(1);
                        n_new   = 3'(r_count);
                    end
                    n_state = vct_pkg::S_RESP;
                end
            end

            vct_pkg::S_READ: begin
                n_read  = 16'(va);
                n_state = vct_pkg::S_RESP;
            end

            vct_pkg::S_RESP: begin
                n_state = vct_pkg::S_IDLE;
            end

            default: begin
                n_state = vct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vct_pkg::S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_idx   <= '0;
            r_pidx  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            r_idx   <= n_idx;
            r_pidx  <= n_pidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_ta     <= n_ta;
        r_tb     <= n_tb;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_status <= n_status;
        r_new    <= n_new;
        r_ab     <= n_ab;
        r_ba     <= n_ba;
        r_cmp    <= n_cmp;
        r_read   <= n_read;
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign busy         = (r_state != vct_pkg::S_IDLE);
    assign o_done       = (r_state == vct_pkg::S_RESP);
    assign o_status     = r_status;
    assign o_new_thread = r_new;
    assign o_a_before_b = r_cmp & r_ab;
    assign o_b_before_a = r_cmp & r_ba;
    assign o_concurrent = r_cmp & ~r_ab & ~r_ba;
    assign o_read_value = r_read;

endmodule
